/* rtl/sio_pkg.sv */
`default_nettype none

package sio_pkg;

  // Channel and register pointer geometry
  localparam int unsigned NumCh = 4;
  localparam int unsigned ChW   = 2;
  localparam int unsigned PtrW  = 3;

  // Register index bit positions
  localparam int unsigned RegChBit   = 0;
  localparam int unsigned RegCtrlBit = 1;
  localparam int unsigned RegChipBit = 2;

  // WR1 bit positions: TX interrupt enable and receive interrupt mode
  localparam int unsigned Wr1TxIntBit  = 1;
  localparam int unsigned Wr1ModeLoBit = 3;
  localparam int unsigned Wr1ModeHiBit = 4;

  // WR0 command field position
  localparam int unsigned CmdLoBit = 3;
  localparam int unsigned CmdHiBit = 5;

  // Register pointer values of interest
  localparam logic [PtrW-1:0] PTR_WR0 = 3'd0;
  localparam logic [PtrW-1:0] PTR_WR1 = 3'd1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_STATUS = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_CH_RESET = 3'd3,
    CMD_ARM_RX   = 3'd4,
    CMD_CLR_TX   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    RX_INT_OFF      = 2'd0,
    RX_INT_IF_ARMED = 2'd1,
    RX_INT_ALL      = 2'd2,
    RX_INT_ALL_ALT  = 2'd3
  } rx_mode_e;

endpackage

`default_nettype wire

/* rtl/sio_if.sv */
`default_nettype none

interface sio_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [2:0]                   reg_index;
  logic [7:0]                   write_data;
  logic [sio_pkg::NumCh-1:0]    rx_nonempty;
  logic [sio_pkg::NumCh-1:0]    tx_int_set;

  modport source (
    output valid, opcode, reg_index, write_data, rx_nonempty, tx_int_set,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_index, write_data, rx_nonempty, tx_int_set,
    output ready
  );
endinterface

interface sio_out_if;
  logic                         valid;
  logic                         ready;
  logic                         int_pending;
  logic                         tx_valid;
  logic [7:0]                   tx_byte;
  logic                         reset_valid;
  logic [sio_pkg::ChW-1:0]      access_channel;

  modport source (
    output valid, int_pending, tx_valid, tx_byte, reset_valid, access_channel,
    input  ready
  );
  modport sink (
    input  valid, int_pending, tx_valid, tx_byte, reset_valid, access_channel,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/serial_io_register_interface.sv */
// Register interface of a four-channel serial controller (two dual-channel
// chips). Channel in_i carries one item per host bus access or status update:
// opcode, reg_index, write_data, and the per-channel rx_nonempty and
// tx_int_set flags. Channel out_o returns exactly one result per item:
// int_pending, tx_valid/tx_byte for the transmit ring, reset_valid for a
// channel reset command, and access_channel. Both use valid/ready; an item
// moves when both are high.
// An accepted item is held in the input register, then passes the decode
// and state update into the result register, from which its result leaves
// out_o.
// Throughput is one item per cycle while out_o does not stall; the channel
// state (WR1, pointer, TX pending, receive armed) is updated in the same
// cycle the result is registered, so the next item sees it without a bubble.
// Reset clears all channel state and both stage valids; in_i.ready is high
// right after reset. When out_o stalls, the result holds and the input
// register still fills, so two items are held before in_i.ready drops.
`default_nettype none

module serial_io_register_interface (
  input  wire       clk_i,
  input  wire       rst_ni,
  sio_in_if.sink    in_i,
  sio_out_if.source out_o
);

  sio_in_if stage_if ();

  sio_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (stage_if)
  );

  sio_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stage_if),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

/* rtl/sio_in_stage.sv */
`default_nettype none

module sio_in_stage (
  input  wire   clk_i,
  input  wire   rst_ni,
  sio_in_if.sink   in_i,
  sio_in_if.source out_o
);
  import sio_pkg::*;

  logic             valid_q;
  logic             opcode_q;
  logic [2:0]       reg_index_q;
  logic [7:0]       write_data_q;
  logic [NumCh-1:0] rx_nonempty_q;
  logic [NumCh-1:0] tx_int_set_q;
  logic             load;

  // Take a new item when empty or when the held item moves on
  assign in_i.ready = !valid_q || out_o.ready;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      opcode_q      <= in_i.opcode;
      reg_index_q   <= in_i.reg_index;
      write_data_q  <= in_i.write_data;
      rx_nonempty_q <= in_i.rx_nonempty;
      tx_int_set_q  <= in_i.tx_int_set;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.opcode      = opcode_q;
  assign out_o.reg_index   = reg_index_q;
  assign out_o.write_data  = write_data_q;
  assign out_o.rx_nonempty = rx_nonempty_q;
  assign out_o.tx_int_set  = tx_int_set_q;

endmodule

`default_nettype wire

/* rtl/sio_core.sv */
`default_nettype none

module sio_core (
  input  wire   clk_i,
  input  wire   rst_ni,
  sio_in_if.sink    in_i,
  sio_out_if.source out_o
);
  import sio_pkg::*;

  // Channel state: WR1, register pointer, TX pending and receive armed
  logic [NumCh-1:0][7:0]      wr1_q, wr1_d;
  logic [NumCh-1:0][PtrW-1:0] ptr_q, ptr_d;
  logic [NumCh-1:0]           txp_q, txp_d;
  logic [NumCh-1:0]           armed_q, armed_d;

  // Result register
  logic           res_valid_q;
  logic           res_int_q;
  logic           res_tx_valid_q;
  logic [7:0]     res_tx_byte_q;
  logic           res_reset_q;
  logic [ChW-1:0] res_ch_q;

  logic           advance;
  logic [ChW-1:0] ch;
  logic           is_write;
  logic           is_ctrl;
  logic [2:0]     cmd;
  logic [PtrW-1:0] ptr_cur;
  logic           chan_reset;
  logic           tx_valid;
  logic [7:0]     tx_byte;
  logic [ChW-1:0] acc_ch;
  logic [NumCh-1:0] avail;
  logic [NumCh-1:0] irq;
  rx_mode_e       mode [NumCh];

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign advance    = in_i.valid && in_i.ready;

  // Decode the item and compute next channel state
  always_comb begin
    ch       = {in_i.reg_index[RegChipBit], in_i.reg_index[RegChBit]};
    is_write = opcode_e'(in_i.opcode) == OP_WRITE;
    is_ctrl  = in_i.reg_index[RegCtrlBit];
    cmd      = in_i.write_data[CmdHiBit:CmdLoBit];
    ptr_cur  = ptr_q[ch];

    wr1_d      = wr1_q;
    ptr_d      = ptr_q;
    armed_d    = armed_q;
    txp_d      = txp_q | in_i.tx_int_set;
    chan_reset = 1'b0;
    tx_valid   = 1'b0;
    tx_byte    = '0;
    acc_ch     = '0;

    if (is_write) begin
      acc_ch = ch;
      if (!is_ctrl) begin
        tx_valid = 1'b1;
        tx_byte  = in_i.write_data;
      end else if (ptr_cur == PTR_WR0) begin
        case (cmd_e'(cmd))
          CMD_CH_RESET: begin
            chan_reset = 1'b1;
            wr1_d[ch]  = '0;
            txp_d[ch]  = 1'b0;
            armed_d[ch] = 1'b0;
          end
          CMD_ARM_RX: armed_d[ch] = 1'b1;
          CMD_CLR_TX: txp_d[ch]   = 1'b0;
          default: ;
        endcase
        // Channel reset leaves the pointer at zero
        ptr_d[ch] = chan_reset ? PTR_WR0 : in_i.write_data[PtrW-1:0];
      end else begin
        if (ptr_cur == PTR_WR1) begin
          wr1_d[ch] = in_i.write_data;
        end
        ptr_d[ch] = PTR_WR0;
      end
    end
  end

  // Per-channel interrupt request from the updated state
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      avail[c] = in_i.rx_nonempty[c] && !(chan_reset && ch == c[ChW-1:0]);
      mode[c]  = rx_mode_e'(wr1_d[c][Wr1ModeHiBit:Wr1ModeLoBit]);
      irq[c]   = wr1_d[c][Wr1TxIntBit] && txp_d[c];
      case (mode[c]) inside
        RX_INT_IF_ARMED:            irq[c] = irq[c] || (avail[c] && armed_d[c]);
        RX_INT_ALL, RX_INT_ALL_ALT: irq[c] = irq[c] || avail[c];
        default: ;
      endcase
    end
  end

  // Commit state when an item passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr1_q   <= '0;
      ptr_q   <= '0;
      txp_q   <= '0;
      armed_q <= '0;
    end else if (advance) begin
      wr1_q   <= wr1_d;
      ptr_q   <= ptr_d;
      txp_q   <= txp_d;
      armed_q <= armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      res_valid_q <= in_i.valid;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_int_q      <= |irq;
      res_tx_valid_q <= tx_valid;
      res_tx_byte_q  <= tx_byte;
      res_reset_q    <= chan_reset;
      res_ch_q       <= acc_ch;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.int_pending    = res_int_q;
  assign out_o.tx_valid       = res_tx_valid_q;
  assign out_o.tx_byte        = res_tx_byte_q;
  assign out_o.reset_valid    = res_reset_q;
  assign out_o.access_channel = res_ch_q;

  // Channel state only moves when an item passes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(wr1_q) && $stable(ptr_q) && $stable(txp_q) && $stable(armed_q))
    else $error("channel state changed without an item");

  // Channel reset clears WR1, pointer, armed and TX pending of that channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && chan_reset |=> ptr_q[$past(ch)] == PTR_WR0 && !armed_q[$past(ch)]
                              && !txp_q[$past(ch)] && wr1_q[$past(ch)] == '0)
    else $error("channel reset left state behind");

  // A write through a nonzero pointer returns the pointer to WR0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_write && is_ctrl && ptr_cur != PTR_WR0 |=> ptr_q[$past(ch)] == PTR_WR0)
    else $error("pointer not cleared after register write");

  // A transmit byte and a channel reset never come from the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_tx_valid_q |-> !res_reset_q)
    else $error("transmit byte and channel reset in one result");

endmodule

`default_nettype wire
